// ===== src/tfec_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfec_pkg: shared constants and types of the trip / fuel efficiency computer
// Field widths, register reset values, scale factors and divider status.
// ----------------------------------------------------------------------------
package tfec_pkg;

    // field and state widths
    localparam int SPEED_W = 17;
    localparam int FUEL_W  = 32;
    localparam int TRIP_W  = 32;
    localparam int MASS_W  = 40;
    localparam int EFF_W   = 24;
    localparam int CNT_W   = 8;
    localparam int WIN_W   = 8;
    localparam int MIN_W   = 24;

    // divider operand widths: numerator holds trip * 256000 (< 2^50)
    localparam int NUM_W = 50;
    localparam int DEN_W = MASS_W;
    localparam int QUO_W = EFF_W;

    // register reset values
    localparam logic [WIN_W-1:0] WIN_RESET      = 8'd60;
    localparam logic [MIN_W-1:0] MIN_MASS_RESET = 24'd100000;

    // register indexes (byte address bit 2)
    localparam logic REG_WINDOW   = 1'b0;
    localparam logic REG_MIN_MASS = 1'b1;

    // trip distance per tick: floor(speed_q8 * 250 / 2304) mm
    localparam logic [7:0]       TRIP_SCALE = 8'd250;
    localparam logic [DEN_W-1:0] TRIP_DIV   = 40'd2304;

    // efficiency numerator: trip * 256000 = (trip * 125) << 11
    localparam logic [6:0] EFF_SCALE = 7'd125;
    localparam int         EFF_SHIFT = 11;

    // divider status back to the controller
    typedef struct packed {
        logic done;
        logic ovf;
    } div_status_t;

endpackage

// ===== src/tfec_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfec_div: bit-serial restoring divider
// One quotient bit per cycle, numerator shifted in MSB first. Quotient bits
// above the kept width set a sticky overflow flag.
// ----------------------------------------------------------------------------
module tfec_div #(
    parameter int NumW = tfec_pkg::NUM_W,
    parameter int DenW = tfec_pkg::DEN_W,
    parameter int QuoW = tfec_pkg::QUO_W
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [NumW-1:0]         numer,
    input  logic [DenW-1:0]         denom,
    output logic [QuoW-1:0]         quot,
    output tfec_pkg::div_status_t   status
);
    import tfec_pkg::*;

    localparam int CntW = $clog2(NumW + 1);

    logic [NumW-1:0] num_reg, num_next;
    logic [DenW-1:0] den_reg, den_next;
    logic [DenW-1:0] rem_reg, rem_next;
    logic [QuoW-1:0] quo_reg, quo_next;
    logic            ovf_reg, ovf_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;

    logic [DenW:0]   rem_shift;
    logic [DenW:0]   rem_diff;
    logic            qbit;

    // one restoring step: shift in next numerator bit, trial subtract
    always_comb begin
        rem_shift = {rem_reg, num_reg[NumW-1]};
        rem_diff  = rem_shift - {1'b0, den_reg};
        qbit      = (rem_shift >= {1'b0, den_reg});
    end

    always_comb begin
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            num_next  = numer;
            den_next  = denom;
            rem_next  = '0;
            quo_next  = '0;
            ovf_next  = 1'b0;
            cnt_next  = CntW'(NumW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            num_next = {num_reg[NumW-2:0], 1'b0};
            rem_next = qbit ? rem_diff[DenW-1:0] : rem_shift[DenW-1:0];
            quo_next = {quo_reg[QuoW-2:0], qbit};
            ovf_next = ovf_reg | quo_reg[QuoW-1];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        ovf_reg <= ovf_next;
    end

    assign quot        = quo_reg;
    assign status.done = done_reg;
    assign status.ovf  = ovf_reg;

endmodule

// ===== src/trip_fuel_efficiency_computer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trip_fuel_efficiency_computer_core: trip distance and fuel efficiency
// Channel  Dir  Payload
// s_       in   tuser: action; tdata: speed_q8, fuel_mass_ug
// m_       out  tuser: efficiency_updated; tdata: rate, efficiency, trip_mm
// APB      in   window_seconds @0x0, min_mass_ug @0x4
//
// A trip tick runs a 50-step bit-serial divide of speed_q8 * 250 by 2304;
// a fuel tick that closes a window with enough mass runs a 50-step divide
// trip*256000 / mass, and any other fuel tick bypasses the divider.
// The serial divider produces one quotient bit per cycle.
// One item is in work at a time; the result register lets the next item be
// taken while a result waits. m_tready low holds the finished item.
// Synchronous active-low reset clears all accumulators and the hold values.
// ----------------------------------------------------------------------------
module trip_fuel_efficiency_computer_core (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // [16:0] speed_q8, [48:17] fuel_mass_ug
    input  logic        s_tuser,   // [0] action
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // [31:0] rate, [55:32] eff, [87:56] trip_mm
    output logic        m_tuser,   // [0] efficiency_updated
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tfec_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_CHECK, S_DIV, S_DONE} state_t;

    state_t state_reg, state_next;

    logic [WIN_W-1:0]  win_reg;
    logic [MIN_W-1:0]  min_reg;
    logic [TRIP_W-1:0] trip_reg, trip_next;
    logic [MASS_W-1:0] mass_reg, mass_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [FUEL_W-1:0] rate_reg, rate_next;
    logic [EFF_W-1:0]  eff_reg, eff_next;
    logic              upd_reg, upd_next;
    logic              trip_op_reg, trip_op_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [87:0]       m_tdata_reg, m_tdata_next;
    logic              m_tuser_reg, m_tuser_next;

    logic                  s_xfer;
    logic                  out_load;
    logic [SPEED_W-1:0]    in_speed;
    logic [FUEL_W-1:0]     in_fuel;
    logic [MASS_W:0]       mass_sum;
    logic [TRIP_W:0]       trip_sum;
    logic [SPEED_W+7:0]    speed_prod;
    logic [TRIP_W+6:0]     eff_prod;
    logic                  cfg_wr;

    logic                  div_start;
    logic [NUM_W-1:0]      div_num;
    logic [DEN_W-1:0]      div_den;
    logic [QUO_W-1:0]      div_quot;
    div_status_t           div_status;

    // input unpacking
    assign in_speed = s_tdata[SPEED_W-1:0];
    assign in_fuel  = s_tdata[SPEED_W+FUEL_W-1:SPEED_W];
    assign s_tready = (state_reg == S_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign out_load = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);

    // products feeding the divider (registered inside it), sums feeding the mass and trip accumulators
    assign speed_prod = in_speed * TRIP_SCALE;
    assign eff_prod   = trip_reg * EFF_SCALE;
    assign mass_sum   = {1'b0, mass_reg} + {{(MASS_W+1-FUEL_W){1'b0}}, in_fuel};
    assign trip_sum   = {1'b0, trip_reg} + {{(TRIP_W+1-QUO_W){1'b0}}, div_quot};

    // sequencer
    always_comb begin
        state_next    = state_reg;
        trip_next     = trip_reg;
        mass_next     = mass_reg;
        cnt_next      = cnt_reg;
        rate_next     = rate_reg;
        eff_next      = eff_reg;
        upd_next      = upd_reg;
        trip_op_next  = trip_op_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        div_start     = 1'b0;
        div_num       = {{(NUM_W-SPEED_W-8){1'b0}}, speed_prod};
        div_den       = TRIP_DIV;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_xfer) begin
                    upd_next     = 1'b0;
                    trip_op_next = !s_tuser;
                    if (!s_tuser) begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end else begin
                        rate_next = in_fuel;
                        mass_next = mass_sum[MASS_W] ? {MASS_W{1'b1}} : mass_sum[MASS_W-1:0];
                        if (cnt_reg != {CNT_W{1'b1}}) begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (cnt_reg >= win_reg) begin
                    upd_next = 1'b1;
                    if (mass_reg > {{(MASS_W-MIN_W){1'b0}}, min_reg}) begin
                        div_start  = 1'b1;
                        div_num    = {eff_prod, {EFF_SHIFT{1'b0}}};
                        div_den    = mass_reg;
                        state_next = S_DIV;
                    end else begin
                        eff_next   = '0;
                        trip_next  = '0;
                        mass_next  = '0;
                        cnt_next   = '0;
                        state_next = S_DONE;
                    end
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DIV: begin
                if (div_status.done) begin
                    if (trip_op_reg) begin
                        trip_next = trip_sum[TRIP_W] ? {TRIP_W{1'b1}} : trip_sum[TRIP_W-1:0];
                    end else begin
                        eff_next  = div_status.ovf ? {EFF_W{1'b1}} : div_quot;
                        trip_next = '0;
                        mass_next = '0;
                        cnt_next  = '0;
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {trip_reg, eff_reg, rate_reg};
                    m_tuser_next  = upd_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            trip_reg     <= '0;
            mass_reg     <= '0;
            cnt_reg      <= '0;
            rate_reg     <= '0;
            eff_reg      <= '0;
            upd_reg      <= 1'b0;
            trip_op_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            trip_reg     <= trip_next;
            mass_reg     <= mass_next;
            cnt_reg      <= cnt_next;
            rate_reg     <= rate_next;
            eff_reg      <= eff_next;
            upd_reg      <= upd_next;
            trip_op_reg  <= trip_op_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // shared serial divider
    tfec_div #(
        .NumW(NUM_W),
        .DenW(DEN_W),
        .QuoW(QUO_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (div_num),
        .denom   (div_den),
        .quot    (div_quot),
        .status  (div_status)
    );

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= WIN_RESET;
            min_reg <= MIN_MASS_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_WINDOW:   win_reg <= pwdata[WIN_W-1:0];
                REG_MIN_MASS: min_reg <= pwdata[MIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_WINDOW:   prdata = {{(32-WIN_W){1'b0}}, win_reg};
            REG_MIN_MASS: prdata = {{(32-MIN_W){1'b0}}, min_reg};
            default:      prdata = '0;
        endcase
    end

endmodule
